/* rtl/column_null_skipping_aggregator_core_assert.svh */
// Assertion macros shared by the RTL.
`ifndef COLUMN_NULL_SKIPPING_AGGREGATOR_CORE_ASSERT_SVH
`define COLUMN_NULL_SKIPPING_AGGREGATOR_CORE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define CNSA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define CNSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/cnsa_pkg.sv */
// ----------------------------------------------------------------------------
// cnsa_pkg
// Types and constants for the column aggregator.
// ----------------------------------------------------------------------------
package cnsa_pkg;

    localparam int VAL_W  = 32;
    localparam int MEAN_W = 40;
    localparam int FCNT_W = 11;
    localparam int DCNT_W = 9;

    localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

    // Input word
    typedef struct packed {
        logic signed [VAL_W-1:0] cell_value;
        logic                    cell_empty;
        logic                    last_cell;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic signed [VAL_W-1:0]  total;
        logic signed [VAL_W-1:0]  smallest;
        logic signed [VAL_W-1:0]  largest;
        logic [FCNT_W-1:0]        filled_count;
        logic [DCNT_W-1:0]        distinct_count;
        logic signed [MEAN_W-1:0] mean_fixed;
        logic                     mean_valid;
        logic                     distinct_overflow;
    } out_word_t;

    // Token moving down the distinct-value chain
    typedef struct packed {
        logic             vld;    // token present
        logic             live;   // non-empty cell
        logic             last;   // final cell of the column
        logic             hit;    // value already placed or matched
        logic             fresh;  // value claimed a new cell
        logic [VAL_W-1:0] val;
    } tok_t;

endpackage

/* rtl/cnsa_ifs.sv */
// ----------------------------------------------------------------------------
// cnsa_ifs
// Valid/ready channels for input cells and result words.
// ----------------------------------------------------------------------------
interface cnsa_in_if
    import cnsa_pkg::*;
;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cnsa_out_if
    import cnsa_pkg::*;
;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/column_null_skipping_aggregator_core.sv */
// ----------------------------------------------------------------------------
// column_null_skipping_aggregator_core
// Sum, min, max, count, distinct count and mean of one table column.
// ----------------------------------------------------------------------------
// Usage:
//   cells  : one word per column cell (value, empty flag, last flag).
//   result : one word per column, issued after the word marked last.
//   Within a column a cell word is taken every cycle. Empty cells are
//   skipped. Each value walks a row of DISTINCT_CELLS cells, one per cycle,
//   that holds the distinct values seen so far.
//   After the last word is taken, cells is held off while that word walks
//   the row and the mean is divided out one bit per cycle; the result then
//   waits in an output register.
//   If the receiver stalls, the result holds and cells stays not ready
//   until it is taken.
//   Reset empties the distinct set (flip-flop valid bits) and clears the
//   running aggregates; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "column_null_skipping_aggregator_core_assert.svh"

module column_null_skipping_aggregator_core
    import cnsa_pkg::*;
#(
    parameter int DISTINCT_CELLS = 256,
    parameter int MAX_ROWS       = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    cnsa_in_if.sink    cells,
    cnsa_out_if.source result
);

    localparam int CW  = $clog2(MAX_ROWS + 1);
    localparam int DCW = $clog2(DISTINCT_CELLS + 1);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic                    acc;
    logic                    live;
    logic signed [VAL_W-1:0] v;

    // running aggregates and column snapshot
    logic [VAL_W-1:0]        tot_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] max_reg;
    logic [CW-1:0]           cnt_reg;
    logic [VAL_W-1:0]        htot_reg;
    logic signed [VAL_W-1:0] hmin_reg;
    logic signed [VAL_W-1:0] hmax_reg;
    logic [CW-1:0]           hcnt_reg;
    logic [VAL_W-1:0]        tot_new;
    logic signed [VAL_W-1:0] min_new;
    logic signed [VAL_W-1:0] max_new;
    logic [CW-1:0]           cnt_new;

    // tail of the chain
    logic [DCW-1:0]          dcnt_reg;
    logic                    ovf_reg;
    logic [DCW-1:0]          hdcnt_reg;
    logic                    hovf_reg;
    logic                    tail_last;

    out_word_t               res_reg;
    tok_t                    tok [0:DISTINCT_CELLS];

    logic [MEAN_W-1:0]       sx;
    logic [MEAN_W-1:0]       mag;
    logic                    div_done;
    logic [MEAN_W-1:0]       quo;
    logic [MEAN_W-1:0]       mean;

    assign acc         = cells.valid && cells.ready;
    assign cells.ready = (state_reg == S_RUN);
    assign live        = !cells.data.cell_empty;
    assign v           = cells.data.cell_value;

    // aggregate update for the incoming word
    always_comb
    begin
        tot_new = tot_reg;
        min_new = min_reg;
        max_new = max_reg;
        cnt_new = cnt_reg;
        if (live)
        begin
            tot_new = tot_reg + v;
            if (v < min_reg)
            begin
                min_new = v;
            end
            if (v > max_reg)
            begin
                max_new = v;
            end
            if (cnt_reg < CW'(MAX_ROWS))
            begin
                cnt_new = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg <= '0;
            min_reg <= INT_MAX;
            max_reg <= INT_MIN;
            cnt_reg <= '0;
        end
        else if (acc)
        begin
            if (cells.data.last_cell)
            begin
                tot_reg <= '0;
                min_reg <= INT_MAX;
                max_reg <= INT_MIN;
                cnt_reg <= '0;
            end
            else
            begin
                tot_reg <= tot_new;
                min_reg <= min_new;
                max_reg <= max_new;
                cnt_reg <= cnt_new;
            end
        end
    end

    // column snapshot at the last word
    always_ff @(posedge clk)
    begin
        if (acc && cells.data.last_cell)
        begin
            htot_reg <= tot_new;
            hmin_reg <= min_new;
            hmax_reg <= max_new;
            hcnt_reg <= cnt_new;
        end
    end

    // token entering the chain; empty non-last cells send nothing
    always_comb
    begin
        tok[0].vld   = acc && (live || cells.data.last_cell);
        tok[0].live  = live;
        tok[0].last  = cells.data.last_cell;
        tok[0].hit   = 1'b0;
        tok[0].fresh = 1'b0;
        tok[0].val   = cells.data.cell_value;
    end

    for (genvar i = 0; i < DISTINCT_CELLS; i++)
    begin : g_cell
        cnsa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .tin   (tok[i]),
            .tout  (tok[i+1])
        );
    end

    // distinct count and overflow at the chain end
    assign tail_last = tok[DISTINCT_CELLS].vld && tok[DISTINCT_CELLS].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (tok[DISTINCT_CELLS].vld)
        begin
            if (tail_last)
            begin
                dcnt_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (tok[DISTINCT_CELLS].live)
            begin
                if (tok[DISTINCT_CELLS].fresh)
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                if (!tok[DISTINCT_CELLS].hit)
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_last)
        begin
            hdcnt_reg <= dcnt_reg + DCW'(tok[DISTINCT_CELLS].live
                                         && tok[DISTINCT_CELLS].fresh);
            hovf_reg  <= ovf_reg || (tok[DISTINCT_CELLS].live
                                     && !tok[DISTINCT_CELLS].hit);
        end
    end

    // mean: |total * 256| / count, sign restored afterwards
    assign sx  = {htot_reg, 8'b0};
    assign mag = htot_reg[VAL_W-1] ? (~sx + 1'b1) : sx;

    cnsa_div #(.VW(CW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tail_last),
        .dividend (mag),
        .divisor  (hcnt_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        if (hcnt_reg == '0)
        begin
            mean = '0;
        end
        else if (htot_reg[VAL_W-1])
        begin
            mean = ~quo + 1'b1;
        end
        else
        begin
            mean = quo;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
        begin
            res_reg.total             <= htot_reg;
            res_reg.smallest          <= hmin_reg;
            res_reg.largest           <= hmax_reg;
            res_reg.filled_count      <= FCNT_W'(hcnt_reg);
            res_reg.distinct_count    <= DCNT_W'(hdcnt_reg);
            res_reg.mean_fixed        <= mean;
            res_reg.mean_valid        <= (hcnt_reg != '0);
            res_reg.distinct_overflow <= hovf_reg;
        end
    end

    assign result.valid = (state_reg == S_OUT);
    assign result.data  = res_reg;

    // column sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                if (acc && cells.data.last_cell)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (tail_last)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (result.ready)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks
    `CNSA_ASSERT_NOW(a_no_tail_outside_wait, tail_last, state_reg == S_WAIT)
    `CNSA_ASSERT_NOW(a_empty_mean_zero, result.valid && !result.data.mean_valid,
                     result.data.mean_fixed == '0)
    `CNSA_ASSERT_NEXT(a_last_blocks_input, acc && cells.data.last_cell, !cells.ready)

endmodule

/* rtl/cnsa_cell.sv */
// ----------------------------------------------------------------------------
// cnsa_cell
// One entry of the distinct-value set; passes the token on each cycle.
// ----------------------------------------------------------------------------
module cnsa_cell
    import cnsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  tok_t tin,
    output tok_t tout
);

    logic             occ_reg;
    logic [VAL_W-1:0] val_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             match;
    logic             claim;

    // compare against stored entry, claim if free
    assign match = tin.vld && tin.live && occ_reg && (val_reg == tin.val);
    assign claim = tin.vld && tin.live && !tin.hit && !occ_reg;

    // occupancy; the last token of a column empties the entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (tin.vld && tin.last)
        begin
            occ_reg <= 1'b0;
        end
        else if (claim)
        begin
            occ_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            val_reg <= tin.val;
        end
    end

    // token with this entry's outcome folded in
    always_comb
    begin
        tok_next       = tin;
        tok_next.hit   = tin.hit | match | claim;
        tok_next.fresh = tin.fresh | claim;
    end

    // hand token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tout = tok_reg;

endmodule

/* rtl/cnsa_div.sv */
// ----------------------------------------------------------------------------
// cnsa_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module cnsa_div
    import cnsa_pkg::*;
#(
    parameter int VW = 11
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MEAN_W-1:0] dividend,
    input  logic [VW-1:0]     divisor,
    output logic              done,
    output logic [MEAN_W-1:0] quotient
);

    localparam int SW = $clog2(MEAN_W);

    logic              run_reg;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic [MEAN_W-1:0] dvd_reg;
    logic [VW-1:0]     rem_reg;
    logic [VW-1:0]     dv_reg;
    logic [VW:0]       sh;
    logic [VW:0]       diff;
    logic              ge;

    // one shift-subtract step
    always_comb
    begin
        sh   = {rem_reg, dvd_reg[MEAN_W-1]};
        ge   = (sh >= {1'b0, dv_reg});
        diff = sh - {1'b0, dv_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == SW'(MEAN_W - 1));
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == SW'(MEAN_W - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dv_reg  <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[VW-1:0] : sh[VW-1:0];
            dvd_reg <= {dvd_reg[MEAN_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
